// ===== rtl/core/rsag_pkg.sv =====
// Package with shared constants for the running statistics anomaly gate.
package rsag_pkg;

  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_OR = 4'd1;
  localparam logic [3:0] OP_NOT = 4'd2;
  localparam logic [3:0] OP_TRUE = 4'd3;
  localparam logic [3:0] OP_FALSE = 4'd4;
  localparam logic [3:0] OP_FLAG0 = 4'd8;
  localparam logic [3:0] OP_FLAG1 = 4'd9;
  localparam logic [3:0] OP_FLAG2 = 4'd10;
  localparam logic [3:0] OP_FLAG3 = 4'd11;

  localparam logic [2:0] REG_MIN_COUNT = 3'd0;
  localparam logic [2:0] REG_ATTR_COUNT = 3'd1;
  localparam logic [2:0] REG_K0 = 3'd2;
  localparam logic [2:0] REG_K1 = 3'd3;
  localparam logic [2:0] REG_K2 = 3'd4;
  localparam logic [2:0] REG_K3 = 3'd5;
  localparam logic [2:0] REG_PROGRAM = 3'd6;
  localparam logic [2:0] REG_PROG_LEN = 3'd7;

  localparam logic [15:0] COUNT_FULL = 16'hFFFF;
  localparam logic [22:0] DEV_MAX = 23'h7FFFFF;

endpackage

// ===== rtl/core/running_stats_anomaly_gate.sv =====
// Top level of the running statistics anomaly gate with its shared sequencer.
// The last attribute of an object also runs the flag program, one op at a time.
// The shared subtract/shift divider runs the 40-step mean division and the 64-step
// mean-square division; a separate 32-step square root follows. The next input
// follows the result transfer; a zero count skips both divisions and the root.
// Reset (rst_n, synchronous, active low) clears stats, position and flags and sets registers to defaults.
module running_stats_anomaly_gate #(
  parameter int NUM_ATTRS = 4,
  parameter int PROG_SLOTS = 16,
  parameter int STACK_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [23:0]   in_sample_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_attr_index,
  output logic [15:0]          out_prior_count,
  output logic signed [23:0]   out_prior_mean,
  output logic [22:0]          out_prior_deviation,
  output logic                 out_outlier,
  output logic                 out_object_done,
  output logic                 out_verdict,
  output logic                 out_program_error,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int AW = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int TW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(PROG_SLOTS + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_MDIV = 4'd2;
  localparam logic [3:0] ST_QDIV = 4'd3;
  localparam logic [3:0] ST_MSQ = 4'd4;
  localparam logic [3:0] ST_SQRT = 4'd5;
  localparam logic [3:0] ST_KD = 4'd6;
  localparam logic [3:0] ST_TEST = 4'd7;
  localparam logic [3:0] ST_PROG = 4'd8;
  localparam logic [3:0] ST_OUT = 4'd9;

  logic [15:0] min_count_r;
  logic [2:0]  attr_count_r;
  logic [11:0] k_r [4];
  logic [63:0] prog_r;
  logic [4:0]  prog_len_r;

  logic [15:0] cnt_r [NUM_ATTRS];
  logic signed [39:0] sum_r [NUM_ATTRS];
  logic [63:0] sq_r [NUM_ATTRS];
  logic [AW-1:0] pos_r;
  logic [NUM_ATTRS-1:0] flags_r;

  logic [3:0] state_r;
  logic [6:0] step_r;
  logic [AW-1:0] a_r;
  logic signed [23:0] x_r;
  logic [15:0] c_r;
  logic neg_r;
  logic [63:0] num_r;
  logic [64:0] rem_r;
  logic [63:0] quo_r;
  logic [39:0] mag_r;
  logic signed [23:0] mean_r;
  logic [63:0] var_r;
  logic [63:0] res_r;
  logic [22:0] dev_r;
  logic [35:0] kd_r;
  logic outlier_r;
  logic done_r;
  logic verdict_r;
  logic err_r;
  logic [PW-1:0] pc_r;
  logic [SW-1:0] depth_r;
  logic [STACK_DEPTH-1:0] stk_r;

  logic [3:0] nattrs;
  logic [PW-1:0] plen;
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;
  logic [63:0] sq_try;
  logic [3:0] op;
  logic [NUM_ATTRS-1:0] flags_now;
  logic signed [33:0] x16;
  logic signed [33:0] m16;
  logic signed [36:0] hi;
  logic signed [36:0] lo;
  logic [5:0] lzstep;

  always_comb begin
    if (attr_count_r == 3'd0) begin
      nattrs = 4'd1;
    end else if ({1'b0, attr_count_r} > 4'(NUM_ATTRS)) begin
      nattrs = 4'(NUM_ATTRS);
    end else begin
      nattrs = {1'b0, attr_count_r};
    end
    if (prog_len_r > 5'(PROG_SLOTS)) begin
      plen = PW'(PROG_SLOTS);
    end else begin
      plen = PW'(prog_len_r);
    end
    rem_sh = {rem_r[63:0], num_r[63]};
    rem_sub = rem_sh - {49'd0, c_r};
    lzstep = 6'(7'd31 - step_r);
    sq_try = (res_r << (7'(lzstep) + 7'd1)) | (64'd1 << {lzstep, 1'b0});
    op = prog_r[6'({pc_r, 2'b00}) +: 4];
    flags_now = flags_r;
    x16 = 34'(x_r) <<< 8;
    m16 = 34'(mean_r) <<< 8;
    hi = 37'(m16) + 37'(kd_r);
    lo = 37'(m16) - 37'(kd_r);
  end

  assign in_ready = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_attr_index = 2'(a_r);
  assign out_prior_count = c_r;
  assign out_prior_mean = mean_r;
  assign out_prior_deviation = dev_r;
  assign out_outlier = outlier_r;
  assign out_object_done = done_r;
  assign out_verdict = verdict_r;
  assign out_program_error = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      min_count_r <= '0;
      attr_count_r <= 3'd1;
      for (int i = 0; i < 4; i++) k_r[i] <= 12'd768;
      prog_r <= 64'd3;
      prog_len_r <= 5'd1;
      for (int i = 0; i < NUM_ATTRS; i++) begin
        cnt_r[i] <= '0;
        sum_r[i] <= '0;
        sq_r[i] <= '0;
      end
      pos_r <= '0;
      flags_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cfg_valid) begin
            case (cfg_index)
              rsag_pkg::REG_MIN_COUNT: min_count_r <= cfg_data[15:0];
              rsag_pkg::REG_ATTR_COUNT: attr_count_r <= cfg_data[2:0];
              rsag_pkg::REG_K0: k_r[0] <= cfg_data[11:0];
              rsag_pkg::REG_K1: k_r[1] <= cfg_data[11:0];
              rsag_pkg::REG_K2: k_r[2] <= cfg_data[11:0];
              rsag_pkg::REG_K3: k_r[3] <= cfg_data[11:0];
              rsag_pkg::REG_PROGRAM: prog_r <= cfg_data;
              rsag_pkg::REG_PROG_LEN: prog_len_r <= cfg_data[4:0];
              default: ;
            endcase
          end else if (in_valid) begin
            x_r <= in_sample_value;
            if ({{(4-AW){1'b0}}, pos_r} >= nattrs) begin
              a_r <= '0;
              flags_r <= '0;
            end else begin
              a_r <= pos_r;
            end
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          c_r <= cnt_r[a_r];
          neg_r <= sum_r[a_r][39];
          mag_r <= sum_r[a_r][39] ? 40'(-sum_r[a_r]) : 40'(sum_r[a_r]);
          num_r <= {(sum_r[a_r][39] ? 40'(-sum_r[a_r]) : 40'(sum_r[a_r])), 24'd0};
          rem_r <= '0;
          quo_r <= '0;
          step_r <= '0;
          mean_r <= '0;
          dev_r <= '0;
          kd_r <= '0;
          if (cnt_r[a_r] == 16'd0) begin
            state_r <= ST_KD;
          end else begin
            state_r <= ST_MDIV;
          end
        end
        ST_MDIV: begin
          num_r <= {num_r[62:0], 1'b0};
          if (!rem_sub[64]) begin
            rem_r <= rem_sub;
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[62:0], 1'b0};
          end
          if (step_r == 7'd39) begin
            step_r <= '0;
            state_r <= ST_QDIV;
            num_r <= sq_r[a_r];
          end else begin
            step_r <= step_r + 7'd1;
          end
          if (step_r == 7'd39) begin
            rem_r <= '0;
            mag_r <= !rem_sub[64] ? {quo_r[38:0], 1'b1} : {quo_r[38:0], 1'b0};
            quo_r <= '0;
          end
        end
        ST_QDIV: begin
          num_r <= {num_r[62:0], 1'b0};
          if (!rem_sub[64]) begin
            rem_r <= rem_sub;
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[62:0], 1'b0};
          end
          if (step_r == 7'd63) begin
            step_r <= '0;
            state_r <= ST_MSQ;
            mean_r <= neg_r ? 24'(-mag_r) : 24'(mag_r);
          end else begin
            step_r <= step_r + 7'd1;
          end
        end
        ST_MSQ: begin
          if (quo_r > 64'(mag_r[23:0]) * 64'(mag_r[23:0])) begin
            var_r <= quo_r - 64'(mag_r[23:0]) * 64'(mag_r[23:0]);
          end else begin
            var_r <= '0;
          end
          res_r <= '0;
          step_r <= '0;
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          if (var_r >= sq_try) begin
            var_r <= var_r - sq_try;
            res_r <= res_r | (64'd1 << lzstep);
          end
          if (step_r == 7'd31) begin
            state_r <= ST_KD;
          end else begin
            step_r <= step_r + 7'd1;
          end
        end
        ST_KD: begin
          if (c_r != 16'd0) begin
            dev_r <= (res_r > 64'(rsag_pkg::DEV_MAX)) ? rsag_pkg::DEV_MAX : res_r[22:0];
          end
          state_r <= ST_TEST;
        end
        ST_TEST: begin
          kd_r <= 36'(k_r[(a_r > AW'(3)) ? 2'd3 : 2'(a_r)]) * 36'(dev_r);
          state_r <= ST_PROG;
          step_r <= 7'd127;
        end
        ST_PROG: begin
          if (step_r == 7'd127) begin
            outlier_r <= 1'b0;
            if (c_r > min_count_r && (37'(x16) > hi || 37'(x16) < lo)) begin
              outlier_r <= 1'b1;
              flags_r[a_r] <= 1'b1;
            end
            if (c_r != rsag_pkg::COUNT_FULL) begin
              cnt_r[a_r] <= c_r + 16'd1;
              sum_r[a_r] <= sum_r[a_r] + 40'(x_r);
              sq_r[a_r] <= sq_r[a_r] + 64'(48'(x_r) * 48'(x_r));
            end
            done_r <= 1'b0;
            verdict_r <= 1'b0;
            err_r <= 1'b0;
            pc_r <= '0;
            depth_r <= '0;
            if ({{(4-AW){1'b0}}, a_r} + 4'd1 >= nattrs) begin
              done_r <= 1'b1;
              pos_r <= '0;
              step_r <= '0;
              if (plen == '0) begin
                err_r <= 1'b1;
                state_r <= ST_OUT;
                flags_r <= '0;
              end
            end else begin
              pos_r <= a_r + AW'(1);
              state_r <= ST_OUT;
            end
          end else begin
            if (err_r) begin
              state_r <= ST_OUT;
              flags_r <= '0;
            end else if (pc_r == plen) begin
              if (depth_r != SW'(1)) begin
                err_r <= 1'b1;
              end else begin
                verdict_r <= stk_r[0];
              end
              flags_r <= '0;
              state_r <= ST_OUT;
            end else begin
              pc_r <= pc_r + PW'(1);
              case (op)
                rsag_pkg::OP_AND, rsag_pkg::OP_OR: begin
                  if (depth_r < SW'(2)) begin
                    err_r <= 1'b1;
                  end else begin
                    depth_r <= depth_r - SW'(1);
                    stk_r[TW'(depth_r - SW'(2))] <= (op == rsag_pkg::OP_AND) ?
                      (stk_r[TW'(depth_r - SW'(2))] & stk_r[TW'(depth_r - SW'(1))]) :
                      (stk_r[TW'(depth_r - SW'(2))] | stk_r[TW'(depth_r - SW'(1))]);
                  end
                end
                rsag_pkg::OP_NOT: begin
                  if (depth_r < SW'(1)) err_r <= 1'b1;
                  else stk_r[TW'(depth_r - SW'(1))] <= !stk_r[TW'(depth_r - SW'(1))];
                end
                rsag_pkg::OP_TRUE, rsag_pkg::OP_FALSE, rsag_pkg::OP_FLAG0,
                rsag_pkg::OP_FLAG1, rsag_pkg::OP_FLAG2, rsag_pkg::OP_FLAG3: begin
                  if ((op[3] && {2'b00, op[1:0]} >= nattrs) ||
                      depth_r >= SW'(STACK_DEPTH)) begin
                    err_r <= 1'b1;
                  end else begin
                    depth_r <= depth_r + SW'(1);
                    stk_r[TW'(depth_r)] <= op[3] ? flags_now[op[1:0]] :
                                                   (op == rsag_pkg::OP_TRUE);
                  end
                end
                default: err_r <= 1'b1;
              endcase
            end
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            if (err_r) verdict_r <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/running_stats_anomaly_gate_checker.sv =====
// Checker that predicts and compares every result of the running statistics anomaly gate.
`timescale 1ns / 100ps
module running_stats_anomaly_gate_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [23:0] in_sample_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_attr_index,
  input  logic [15:0]        out_prior_count,
  input  logic signed [23:0] out_prior_mean,
  input  logic [22:0]        out_prior_deviation,
  input  logic               out_outlier,
  input  logic               out_object_done,
  input  logic               out_verdict,
  input  logic               out_program_error,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int NATTR = 4;
  localparam int SLOTS = 16;
  localparam int DEPTH = 16;

  typedef struct packed {
    logic [1:0]         attr_index;
    logic [15:0]        prior_count;
    logic signed [23:0] prior_mean;
    logic [22:0]        prior_deviation;
    logic               outlier;
    logic               object_done;
    logic               verdict;
    logic               program_error;
  } gate_result_t;

  gate_result_t expected_q[$];

  logic [15:0] min_count_r;
  logic [2:0]  attr_count_r;
  logic [11:0] k_r[4];
  logic [63:0] program_r;
  logic [4:0]  prog_len_r;

  logic [15:0]        cnt_r[NATTR];
  logic signed [63:0] sum_r[NATTR];
  logic [63:0]        sumsq_r[NATTR];
  int unsigned        pos_r;
  logic [3:0]         flags_r;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic eval_program(input logic [3:0] flags, input int unsigned nattrs,
                                        output logic verdict);
    logic stk[DEPTH];
    int unsigned sp;
    int unsigned len;
    logic [3:0] op;
    logic v;
    sp = 0;
    verdict = 1'b0;
    len = (prog_len_r > SLOTS) ? SLOTS : prog_len_r;
    for (int s = 0; s < len; s++) begin
      op = program_r[4*s +: 4];
      if (op == rsag_pkg::OP_AND || op == rsag_pkg::OP_OR) begin
        if (sp < 2) return 1'b1;
        sp--;
        if (op == rsag_pkg::OP_AND) stk[sp-1] = stk[sp-1] & stk[sp];
        else stk[sp-1] = stk[sp-1] | stk[sp];
      end else if (op == rsag_pkg::OP_NOT) begin
        if (sp < 1) return 1'b1;
        stk[sp-1] = !stk[sp-1];
      end else if (op == rsag_pkg::OP_TRUE || op == rsag_pkg::OP_FALSE ||
                   (op >= rsag_pkg::OP_FLAG0 && op <= rsag_pkg::OP_FLAG3)) begin
        if (op == rsag_pkg::OP_TRUE) v = 1'b1;
        else if (op == rsag_pkg::OP_FALSE) v = 1'b0;
        else begin
          if (op - rsag_pkg::OP_FLAG0 >= nattrs) return 1'b1;
          v = flags[op - rsag_pkg::OP_FLAG0];
        end
        if (sp >= DEPTH) return 1'b1;
        stk[sp] = v;
        sp++;
      end else begin
        return 1'b1;
      end
    end
    if (sp != 1) return 1'b1;
    verdict = stk[0];
    return 1'b0;
  endfunction

  function automatic gate_result_t score_sample(input logic signed [23:0] sample);
    gate_result_t r;
    int unsigned nattrs;
    int unsigned a;
    logic signed [63:0] x, mean, kd, x16, hi, lo;
    logic [63:0] ms, m2, dev;
    logic vd;
    logic err;
    nattrs = (attr_count_r == 0) ? 1 : (attr_count_r > NATTR) ? NATTR : attr_count_r;
    x = sample;
    mean = 0;
    dev = 0;
    vd = 1'b0;
    err = 1'b0;
    if (pos_r >= nattrs) begin
      pos_r = 0;
      flags_r = '0;
    end
    a = pos_r;
    if (cnt_r[a] != 0) begin
      ms = sumsq_r[a] / {48'd0, cnt_r[a]};
      mean = sum_r[a] / $signed({48'd0, cnt_r[a]});
      m2 = mean * mean;
      if (ms > m2) dev = int_sqrt(ms - m2);
      if (dev > rsag_pkg::DEV_MAX) dev = rsag_pkg::DEV_MAX;
    end
    kd = $signed({52'd0, k_r[a]}) * $signed(dev);
    x16 = x * 256;
    hi = mean * 256 + kd;
    lo = mean * 256 - kd;
    r = '0;
    if (cnt_r[a] > min_count_r && (x16 > hi || x16 < lo)) begin
      r.outlier = 1'b1;
      flags_r[a] = 1'b1;
    end
    r.attr_index = 2'(a);
    r.prior_count = cnt_r[a];
    r.prior_mean = mean[23:0];
    r.prior_deviation = dev[22:0];
    if (cnt_r[a] < rsag_pkg::COUNT_FULL) begin
      cnt_r[a] = cnt_r[a] + 16'd1;
      sum_r[a] = sum_r[a] + x;
      sumsq_r[a] = sumsq_r[a] + x * x;
    end
    if (a + 1 >= nattrs) begin
      r.object_done = 1'b1;
      err = eval_program(flags_r, nattrs, vd);
      r.program_error = err;
      r.verdict = err ? 1'b0 : vd;
      flags_r = '0;
      pos_r = 0;
    end else begin
      pos_r = a + 1;
    end
    return r;
  endfunction

  gate_result_t got;
  gate_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      min_count_r = 0;
      attr_count_r = 1;
      for (int i = 0; i < 4; i++) k_r[i] = 768;
      program_r = 3;
      prog_len_r = 1;
      for (int i = 0; i < NATTR; i++) begin
        cnt_r[i] = 0;
        sum_r[i] = 0;
        sumsq_r[i] = 0;
      end
      pos_r = 0;
      flags_r = '0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rsag_pkg::REG_MIN_COUNT:  min_count_r = cfg_data[15:0];
          rsag_pkg::REG_ATTR_COUNT: attr_count_r = cfg_data[2:0];
          rsag_pkg::REG_K0:         k_r[0] = cfg_data[11:0];
          rsag_pkg::REG_K1:         k_r[1] = cfg_data[11:0];
          rsag_pkg::REG_K2:         k_r[2] = cfg_data[11:0];
          rsag_pkg::REG_K3:         k_r[3] = cfg_data[11:0];
          rsag_pkg::REG_PROGRAM:    program_r = cfg_data;
          rsag_pkg::REG_PROG_LEN:   prog_len_r = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_q.push_back(score_sample(in_sample_value));
      if (out_valid && out_ready) begin
        got = '{out_attr_index, out_prior_count, out_prior_mean, out_prior_deviation,
                out_outlier, out_object_done, out_verdict, out_program_error};
        if (expected_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %p", $time, got);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/running_stats_anomaly_gate_test.sv =====
// Top of the testbench: clock, reset, stimulus, idling phases and the final verdict.
`timescale 1ns / 100ps
module running_stats_anomaly_gate_test;

  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [23:0] in_sample_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_attr_index;
  logic [15:0]        out_prior_count;
  logic signed [23:0] out_prior_mean;
  logic [22:0]        out_prior_deviation;
  logic               out_outlier;
  logic               out_object_done;
  logic               out_verdict;
  logic               out_program_error;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned nattrs_cur = 1;

  always #10 clk = ~clk;

  running_stats_anomaly_gate u_dut (.*);

  running_stats_anomaly_gate_checker u_checker (.*);

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == rsag_pkg::REG_ATTR_COUNT)
      nattrs_cur = (data[2:0] == 0) ? 1 : (data[2:0] > 4) ? 4 : data[2:0];
  endtask

  task automatic send_sample(input logic signed [23:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_value <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_program(input logic [63:0] prog, input logic [4:0] len);
    write_reg(rsag_pkg::REG_PROGRAM, prog);
    write_reg(rsag_pkg::REG_PROG_LEN, {59'd0, len});
  endtask

  // Builds a postfix program leaving exactly one stack value, or a random program.
  task automatic random_program;
    logic [63:0] prog;
    int unsigned len;
    int unsigned sp;
    int unsigned left;
    logic [3:0] op;
    prog = '0;
    len = $urandom_range(1, 16);
    sp = 0;
    for (int s = 0; s < len; s++) begin
      left = len - s;
      if (sp >= 2 && sp >= left) op = $urandom_range(1) ? rsag_pkg::OP_AND : rsag_pkg::OP_OR;
      else if (sp == 0 || (sp + 1 < left && $urandom_range(1))) begin
        case ($urandom_range(5))
          0: op = rsag_pkg::OP_TRUE;
          1: op = rsag_pkg::OP_FALSE;
          default: op = 4'(rsag_pkg::OP_FLAG0 + $urandom_range(nattrs_cur - 1));
        endcase
      end else if (sp >= 2 && $urandom_range(1))
        op = $urandom_range(1) ? rsag_pkg::OP_AND : rsag_pkg::OP_OR;
      else op = rsag_pkg::OP_NOT;
      if (op == rsag_pkg::OP_AND || op == rsag_pkg::OP_OR) sp--;
      else if (op != rsag_pkg::OP_NOT) sp++;
      prog[4*s +: 4] = op;
    end
    if ($urandom_range(4) == 0) load_program({$urandom, $urandom}, 5'($urandom_range(31)));
    else load_program(prog, len[4:0]);
  endtask

  task automatic random_config(input int unsigned phase);
    case (phase % 4)
      0: write_reg(rsag_pkg::REG_MIN_COUNT, 64'd0);
      1: write_reg(rsag_pkg::REG_MIN_COUNT, 64'd65535);
      default: write_reg(rsag_pkg::REG_MIN_COUNT, 64'($urandom_range(8)));
    endcase
    write_reg(rsag_pkg::REG_ATTR_COUNT,
              (phase % 5 == 4) ? 64'($urandom_range(7)) : 64'($urandom_range(1, 4)));
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(3))
        0: write_reg(3'(rsag_pkg::REG_K0 + 3'(i)), 64'd0);
        1: write_reg(3'(rsag_pkg::REG_K0 + 3'(i)), 64'd4095);
        default: write_reg(3'(rsag_pkg::REG_K0 + 3'(i)), 64'($urandom_range(256, 1024)));
      endcase
    end
    random_program();
  endtask

  function automatic logic signed [23:0] random_sample(input int unsigned attr);
    logic signed [23:0] base;
    base = $signed(24'(attr * 24'h1000)) - 24'sh1800;
    case ($urandom_range(9))
      0: return 24'($urandom);
      1: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      2: return base + $signed(24'($urandom_range(40000))) - 24'sd20000;
      default: return base + $signed(24'($urandom_range(512))) - 24'sd256;
    endcase
  endfunction

  initial begin
    int unsigned attr;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: default program, then extremes and program errors.
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh000000);
    drain();
    write_reg(rsag_pkg::REG_ATTR_COUNT, 64'd4);
    write_reg(rsag_pkg::REG_MIN_COUNT, 64'd1);
    write_reg(rsag_pkg::REG_K0, 64'd0);
    write_reg(rsag_pkg::REG_K3, 64'd4095);
    // flag0 flag1 and flag2 or not flag3 or true and false or
    load_program(64'h0000_1403_1B21_A098, 5'd12);
    send_sample(24'sh000100);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sh000001);
    send_sample(24'sh800000);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh000000);
    send_sample(24'shFFFFFF);
    drain();
    load_program(64'h5, 5'd1);
    send_sample(24'sh000010);
    send_sample(24'sh000020);
    drain();
    write_reg(rsag_pkg::REG_ATTR_COUNT, 64'd2);
    load_program(64'hB, 5'd1);
    send_sample(24'sh123456);
    send_sample(24'shEDCBA9);
    drain();
    load_program(64'h0, 5'd0);
    send_sample(24'sh000000);
    send_sample(24'sh000000);
    drain();
    load_program(64'h33, 5'd31);
    send_sample(24'sh555555);
    drain();
    write_reg(rsag_pkg::REG_ATTR_COUNT, 64'd4);
    load_program(64'h0, 5'd2);
    send_sample(24'shAAAAAA);
    send_sample(24'sh000000);
    send_sample(24'sh000000);
    drain();
    write_reg(rsag_pkg::REG_ATTR_COUNT, 64'd2);
    send_sample(24'sh000300);
    drain();
    write_reg(rsag_pkg::REG_ATTR_COUNT, 64'd0);
    send_sample(24'sh000300);
    drain();
    write_reg(rsag_pkg::REG_ATTR_COUNT, 64'd7);
    write_reg(rsag_pkg::REG_K1, 64'd768);
    write_reg(rsag_pkg::REG_K2, 64'd128);
    send_sample(24'sh000300);
    drain();

    // Random part: four idling styles, each with changing settings.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 51; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 51; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      random_config(phase);
      attr = 0;
      for (int n = 0; n < 85; n++) begin
        send_sample(random_sample(attr));
        attr = (attr + 1 >= nattrs_cur) ? 0 : attr + 1;
        if (n == 40 && phase == 3) drain();
      end
      drain();
    end

    repeat (150) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rsag_pkg.sv
rtl/core/running_stats_anomaly_gate.sv
tb/running_stats_anomaly_gate_checker.sv
tb/running_stats_anomaly_gate_test.sv
